[rtl/max_heap_priority_queue_macros.svh]
// Assertion macros for the max-heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mhpq_pkg.sv]
// Shared constants and types of the max-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;
    // Fill count width: holds 0 through CAPACITY.
    localparam int CNT_WIDTH_DEF = $clog2(CAPACITY_DEF + 1);

    // Operation codes of the mode field.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

[rtl/mhpq_if.sv]
// Request and response channel interfaces of the max-heap priority queue.
`timescale 1ns / 1ps

interface mhpq_req_if
    import mhpq_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [KEY_WIDTH-1:0] key_in;

    modport source (output valid, output mode, output key_in, input ready);
    modport sink   (input valid, input mode, input key_in, output ready);
endinterface

interface mhpq_rsp_if
    import mhpq_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int CNT_WIDTH = CNT_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [KEY_WIDTH-1:0] removed_key;
    logic [KEY_WIDTH-1:0] top_key;
    logic [CNT_WIDTH-1:0] entries;
    logic                 empty_error;
    logic                 full_error;

    modport source (output valid, output removed_key, output top_key, output entries,
                    output empty_error, output full_error, input ready);
    modport sink   (input valid, input removed_key, input top_key, input entries,
                    input empty_error, input full_error, output ready);
endinterface

[rtl/max_heap_priority_queue.sv]
// Max-priority queue top level: a chain of key cells kept in descending order.
// Keys sit in a row of CAPACITY cells sorted largest first, so the maximum is
// always in the first cell. An insert is broadcast to all cells at once: each
// cell compares the new key with its own, and the cells at and after the
// insertion point shift one place toward the tail while the new key drops
// into the gap. A remove shifts every cell one place toward the head. A
// request is accepted whenever the response register is empty or being
// drained in the same cycle, and its response appears in the register on
// the next clock. Throughput is one transaction per cycle with a sink that
// is always ready; the response is registered straight after the single
// compare-and-shift step of the cell row. Cells beyond the fill count hold
// stale data that is never read, so there is no clearing pass after reset.
// A remove on an empty queue and an insert on a full queue change nothing
// and are flagged in the response.
`timescale 1ns / 1ps
`include "max_heap_priority_queue_macros.svh"

module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);

    // Fill count holds 0 through CAPACITY.
    localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

    // Fill count and response register.
    logic [CNT_WIDTH-1:0] r_count;
    logic [CNT_WIDTH-1:0] n_count;
    logic                 r_rsp_valid;
    logic [KEY_WIDTH-1:0] r_removed;
    logic [KEY_WIDTH-1:0] r_top;
    logic [CNT_WIDTH-1:0] r_entries;
    logic                 r_empty_err;
    logic                 r_full_err;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_is_ins;
    t_cell_ctrl           w_ctrl;
    logic [KEY_WIDTH-1:0] w_top_next;

    // Cell row wiring.
    logic [KEY_WIDTH-1:0] w_key  [CAPACITY];
    logic                 w_keep [CAPACITY];

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_WIDTH'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_is_ins    = (i_req.mode == MODE_INSERT);

    assign w_ctrl.ins = w_accept && w_is_ins && !w_full;
    assign w_ctrl.del = w_accept && (i_req.mode == MODE_REMOVE) && !w_empty;

    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [KEY_WIDTH-1:0] w_left_key;
            logic                 w_left_keep;
            logic [KEY_WIDTH-1:0] w_right_key;

            if (gi == 0) begin : g_head
                // Nothing precedes the head: a non-keeping head takes the key.
                assign w_left_key  = i_req.key_in;
                assign w_left_keep = 1'b1;
            end else begin : g_body
                assign w_left_key  = w_key[gi-1];
                assign w_left_keep = w_keep[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_right_key = '0;
            end else begin : g_inner
                assign w_right_key = w_key[gi+1];
            end

            mhpq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_key       (i_req.key_in),
                .i_occ       (CNT_WIDTH'(gi) < r_count),
                .i_left_key  (w_left_key),
                .i_left_keep (w_left_keep),
                .i_right_key (w_right_key),
                .o_key       (w_key[gi]),
                .o_keep      (w_keep[gi])
            );
        end
    endgenerate

    // Count and maximum after this transaction.
    always_comb begin
        n_count    = r_count;
        w_top_next = w_empty ? '0 : w_key[0];
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_WIDTH'(1);
            if (w_empty || (i_req.key_in > w_key[0])) begin
                w_top_next = i_req.key_in;
            end
        end else if (w_ctrl.del) begin
            n_count    = r_count - CNT_WIDTH'(1);
            // The second cell becomes the head; none left after the last key.
            w_top_next = (r_count > CNT_WIDTH'(1)) ? w_key[1] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Response payload, loaded with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed   <= w_ctrl.del ? w_key[0] : '0;
            r_top       <= w_top_next;
            r_entries   <= n_count;
            r_empty_err <= !w_is_ins && w_empty;
            r_full_err  <= w_is_ins && w_full;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.removed_key = r_removed;
    assign o_rsp.top_key     = r_top;
    assign o_rsp.entries     = r_entries;
    assign o_rsp.empty_error = r_empty_err;
    assign o_rsp.full_error  = r_full_err;

    `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_WIDTH'(CAPACITY), "fill count over capacity")
    `MHPQ_ASSERT_NEXT(a_ins_count, w_ctrl.ins, r_count == $past(r_count) + CNT_WIDTH'(1), "insert did not grow count")
    `MHPQ_ASSERT_NEXT(a_empty_flag, w_accept && !w_is_ins && w_empty, r_empty_err && r_entries == '0, "empty remove not flagged")
    `MHPQ_ASSERT_NOW(a_flags_excl, r_rsp_valid, !(r_empty_err && r_full_err), "both error flags set")

endmodule

[rtl/mhpq_cell.sv]
// One slot of the sorted key chain: holds a key, shifts or takes the new key.
`timescale 1ns / 1ps

module mhpq_cell
    import mhpq_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic                 i_occ,
    input  logic [KEY_WIDTH-1:0] i_left_key,
    input  logic                 i_left_keep,
    input  logic [KEY_WIDTH-1:0] i_right_key,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic                 o_keep
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;

    // Stay put on insert when holding a key no smaller than the new one.
    assign o_keep = i_occ && (r_key >= i_key);
    assign o_key  = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.ins) begin
            if (!o_keep) begin
                n_key = i_left_keep ? i_key : i_left_key;
            end
        end else if (i_ctrl.del) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
